FILE: design/fstp_pkg.sv
`default_nettype none
package fstp_pkg;

	// fixed field widths
	localparam int TID_W    = 6;
	localparam int NUM_TID  = 64;
	localparam int CLS_W    = 2;
	localparam int RT_W     = 32;
	localparam int WGT_W    = 17;
	localparam int CFG_W    = 8;
	localparam int SLICE_W  = 8;
	localparam int VR_W     = 39;
	localparam int RC_W     = 7;
	localparam int KEY_SCALE_BITS = 10;

	// result status codes
	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_PICK  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// request kinds
	localparam logic FN_ENQ  = 1'b0;
	localparam logic FN_PICK = 1'b1;

	// configuration register indexes
	localparam logic CFG_MIN_SLICE = 1'b0;
	localparam logic CFG_LATENCY   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EN_CALC,
		S_EN_DIV,
		S_SCAN,
		S_SLICE0,
		S_SLICE1,
		S_SL_DIV,
		S_SH_RD,
		S_SH_WR,
		S_FIN,
		S_OUT
	} fsm_t;

	// class weights: system, interactive, normal, batch
	function automatic logic [WGT_W-1:0] class_weight(input logic [CLS_W-1:0] cls);
		logic [WGT_W-1:0] w;
		unique case (cls)
			2'd0: w = 17'd88761;
			2'd1: w = 17'd29154;
			2'd2: w = 17'd1024;
			default: w = 17'd15;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: design/fstp_ram.sv
`default_nettype none
module fstp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: design/fstp_div.sv
`default_nettype none
module fstp_div #(
	parameter int DVD_W = 58,
	parameter int DVS_W = 30
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: design/fair_share_task_picker_top.sv
// channel  dir  handshake           tdata / tuser
// s        in   s_tvalid/s_tready   tid, class, svc_total / func
// m        out  m_tvalid/m_tready   thread, slice, vruntime, count / status
// cfg      in   cfg_we              cfg_idx selects min_slice or target_latency
//
// One request at a time. Enqueue: the bit-serial divider
// (42+KEY_FRACTION_BITS steps) forms the key.
// Pick: a key scan over all count entries, a second divider pass for the
// slice, then each entry behind the picked one is shifted down.
// Reset is immediate: per-thread runtime reads as zero through valid flops.
// A waiting result does not block acceptance of the next request.
`default_nettype none
module fair_share_task_picker_top
	import fstp_pkg::*;
#(
	parameter int MAX_THREADS       = 64,
	parameter int KEY_FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // thread_id[5:0], priority_class[7:6], svc_total[39:8]
	input  wire logic [0:0]  s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // picked_thread, grant_ticks, shown_vruntime, ready_count
	output logic      [1:0]  m_tuser,   // status
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_idx,
	input  wire logic [7:0]  cfg_data
);

	localparam int IDX_W = $clog2(MAX_THREADS);
	localparam int CNT_W = $clog2(MAX_THREADS + 1);
	localparam int P_W   = CNT_W + 1;
	localparam int SUM_W = WGT_W + IDX_W;
	localparam int DEN_W = SUM_W + CNT_W;
	localparam int SH_W  = KEY_SCALE_BITS + KEY_FRACTION_BITS;
	localparam int DVD_W = RT_W + SH_W;
	localparam int KEY_W = DVD_W - 3;
	localparam int ENT_W = KEY_W + TID_W + CLS_W;
	localparam int NUM_W = WGT_W + CFG_W;

	fsm_t state_q, state_d;

	logic [TID_W-1:0]   tid_q;
	logic [CLS_W-1:0]   cls_q;
	logic [RT_W-1:0]    svc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CFG_W-1:0]   min_q;
	logic [CFG_W-1:0]   lat_q;
	logic [NUM_TID-1:0] vld_q;
	status_t            st_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [TID_W-1:0]   best_tid_q;
	logic [CLS_W-1:0]   best_cls_q;
	logic [RC_W-1:0]    rc_q;
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q;
	logic [SLICE_W-1:0] slice_q;
	logic [IDX_W-1:0]   sh_idx_q;
	logic               m_tvalid_q;
	logic [1:0]         m_tuser_q;
	logic [63:0]        m_tdata_q;

	// input fields
	logic [TID_W-1:0] in_tid;
	logic [CLS_W-1:0] in_cls;
	logic [RT_W-1:0]  in_svc;
	logic             accept;
	assign in_tid = s_tdata[5:0];
	assign in_cls = s_tdata[7:6];
	assign in_svc = s_tdata[39:8];
	assign accept = s_tvalid && s_tready;

	// thread memory: {last_service, run_total}
	logic [2*RT_W-1:0] t_rdata;
	logic [RT_W-1:0]   old_rt, old_ls, new_rt;
	logic              t_we;

	fstp_ram #(.WIDTH(2*RT_W), .DEPTH(NUM_TID)) u_thread_mem (
		.clk   (clk),
		.we    (t_we),
		.waddr (tid_q),
		.wdata ({svc_q, new_rt}),
		.raddr (in_tid),
		.rdata (t_rdata)
	);

	always_comb begin
		old_rt = vld_q[tid_q] ? t_rdata[RT_W-1:0] : '0;
		old_ls = vld_q[tid_q] ? t_rdata[2*RT_W-1:RT_W] : '0;
		new_rt = old_rt + (svc_q - old_ls);
	end

	// entry memory: {key, thread, class}, kept compacted in arrival order
	logic             e_we;
	logic [IDX_W-1:0] e_waddr, e_raddr;
	logic [ENT_W-1:0] e_wdata, e_rdata;
	logic [KEY_W-1:0] r_key;
	logic [TID_W-1:0] r_tid;
	logic [CLS_W-1:0] r_cls;

	fstp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_THREADS)) u_entry_mem (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	assign r_cls = e_rdata[CLS_W-1:0];
	assign r_tid = e_rdata[CLS_W +: TID_W];
	assign r_key = e_rdata[ENT_W-1 -: KEY_W];

	// shared divider for key and slice
	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dvd, div_q;
	logic [DEN_W-1:0] div_dvs;

	fstp_div #(.DVD_W(DVD_W), .DVS_W(DEN_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	// index arithmetic one bit wider than the count
	logic [P_W-1:0] cntp, cmp1, sh1, sh2;
	logic           queue_full, scan_take;
	logic [SLICE_W-1:0] share;
	always_comb begin
		cntp       = P_W'(cnt_q);
		cmp1       = P_W'(cmp_idx_q) + P_W'(1);
		sh1        = P_W'(sh_idx_q) + P_W'(1);
		sh2        = P_W'(sh_idx_q) + P_W'(2);
		queue_full = cnt_q == CNT_W'(MAX_THREADS);
		scan_take  = (cmp_idx_q == '0) || (r_key < best_key_q);
		share      = div_q[SLICE_W-1:0];
	end

	// next state and memory / divider controls
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		t_we      = 1'b0;
		e_we      = 1'b0;
		e_waddr   = cnt_q[IDX_W-1:0];
		e_wdata   = {div_q[KEY_W-1:0], tid_q, cls_q};
		e_raddr   = '0;
		div_start = 1'b0;
		div_dvd   = DVD_W'(new_rt) << SH_W;
		div_dvs   = DEN_W'(class_weight(cls_q));
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (s_tuser[0] == FN_ENQ) begin
						state_d = queue_full ? S_OUT : S_EN_CALC;
					end else begin
						state_d = (cnt_q == '0) ? S_OUT : S_SCAN;
					end
				end
			end
			S_EN_CALC: begin
				t_we      = 1'b1;
				div_start = 1'b1;
				state_d   = S_EN_DIV;
			end
			S_EN_DIV: begin
				if (div_done) begin
					e_we    = 1'b1;
					state_d = S_OUT;
				end
			end
			S_SCAN: begin
				e_raddr = cmp1[IDX_W-1:0];
				if (cmp1 == cntp) begin
					state_d = S_SLICE0;
				end
			end
			S_SLICE0: begin
				state_d = S_SLICE1;
			end
			S_SLICE1: begin
				div_dvd = DVD_W'(num_q);
				div_dvs = den_q;
				if (den_q == '0) begin
					state_d = S_SH_RD;
				end else begin
					div_start = 1'b1;
					state_d   = S_SL_DIV;
				end
			end
			S_SL_DIV: begin
				if (div_done) begin
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: begin
				e_raddr = sh1[IDX_W-1:0];
				state_d = (sh1 < cntp) ? S_SH_WR : S_FIN;
			end
			S_SH_WR: begin
				e_we    = 1'b1;
				e_waddr = sh_idx_q;
				e_wdata = e_rdata;
				e_raddr = sh2[IDX_W-1:0];
				if (!(sh2 < cntp)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: count, weight sum, valid bits, config, output valid
	logic [WGT_W-1:0] best_w;
	assign best_w = class_weight(best_cls_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			vld_q      <= '0;
			min_q      <= CFG_W'(3);
			lat_q      <= CFG_W'(48);
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx[0] == CFG_MIN_SLICE) begin
					min_q <= cfg_data;
				end else begin
					lat_q <= cfg_data;
				end
			end
			if (t_we) begin
				vld_q[tid_q] <= 1'b1;
			end
			if (state_q == S_EN_DIV && div_done) begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_q + SUM_W'(class_weight(cls_q));
			end
			if (state_q == S_FIN) begin
				cnt_q <= cnt_q - 1'b1;
				sum_q <= (sum_q >= SUM_W'(best_w)) ? sum_q - SUM_W'(best_w) : '0;
			end
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tid_q     <= in_tid;
			cls_q     <= in_cls;
			svc_q     <= in_svc;
			cmp_idx_q <= '0;
			rc_q      <= RC_W'(cnt_q);
			if (s_tuser[0] == FN_ENQ) begin
				st_q <= queue_full ? ST_FULL : ST_ENQ;
			end else begin
				st_q <= (cnt_q == '0) ? ST_EMPTY : ST_PICK;
			end
		end
		// running minimum, first slot wins ties
		if (state_q == S_SCAN) begin
			cmp_idx_q <= cmp1[IDX_W-1:0];
			if (scan_take) begin
				best_idx_q <= cmp_idx_q;
				best_key_q <= r_key;
				best_tid_q <= r_tid;
				best_cls_q <= r_cls;
			end
		end
		if (state_q == S_SLICE0) begin
			num_q    <= NUM_W'(best_w) * NUM_W'(lat_q);
			den_q    <= DEN_W'(sum_q) * DEN_W'(cnt_q);
			sh_idx_q <= best_idx_q;
			slice_q  <= min_q;
		end
		if (state_q == S_SL_DIV && div_done) begin
			slice_q <= (share > min_q) ? share : min_q;
		end
		if (state_q == S_SH_WR) begin
			sh_idx_q <= sh1[IDX_W-1:0];
		end
		// result register
		if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
			m_tuser_q <= st_q;
			if (st_q == ST_PICK) begin
				m_tdata_q <= {4'b0, rc_q, best_key_q[KEY_W-1 -: VR_W], slice_q, best_tid_q};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

FILE: design/fstp_chk.sv
`default_nettype none
module fstp_chk
	import fstp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// only a pick carries payload
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_PICK |-> m_tdata == 64'd0)
		else $error("non-pick result with payload");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// a new result appears only while the input side is closed
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result issued from idle");

endmodule

bind fair_share_task_picker_top fstp_chk u_fstp_chk (.*);
`default_nettype wire
